FILE: rtl/core/datetime_to_epoch_seconds_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the calendar-to-epoch-seconds core
// Expect clk_i and rst_ni in the scope of the using module.
// ---------------------------------------------------------------------------
`ifndef DATETIME_TO_EPOCH_SECONDS_CORE_MACROS_SVH
`define DATETIME_TO_EPOCH_SECONDS_CORE_MACROS_SVH

// Checked only out of reset.
`define DTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define DTE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: rtl/core/dte_pkg.sv
// ---------------------------------------------------------------------------
// dte_pkg
// Shared types and constants of the calendar-to-epoch-seconds core.
// ---------------------------------------------------------------------------
package dte_pkg;

  localparam int unsigned DaysW = 22;

  // Calendar year of day zero
  localparam logic [11:0] EpochYear = 12'd2010;
  // Leap years in [1, 2010)
  localparam logic [10:0] LeapsBeforeEpoch = 11'd487;
  // floor(x * 656 / 2^14) == floor(x / 25) for x < 1024
  localparam logic [9:0]  Recip25 = 10'd656;
  localparam int unsigned Recip25Shift = 14;

  // Day-of-year offset per month code (day is added, leap day added separately)
  localparam logic [8:0] DoyOffset [16] = '{
    9'd31,  9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd396, 9'd426
  };

  localparam logic [3:0] MonthMarch = 4'd3;

  typedef struct packed {
    logic signed [DaysW-1:0] days;
    logic [4:0]              hour;
    logic [5:0]              minute;
    logic [5:0]              second;
  } dte_days_t;

endpackage

FILE: rtl/core/dte_in_if.sv
// ---------------------------------------------------------------------------
// dte_in_if
// Input channel: one calendar time per beat.
// ---------------------------------------------------------------------------
interface dte_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

FILE: rtl/core/dte_out_if.sv
// ---------------------------------------------------------------------------
// dte_out_if
// Output channel: one elapsed-seconds count per beat.
// ---------------------------------------------------------------------------
interface dte_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] elapsed_seconds;

  modport source (output valid, elapsed_seconds, input ready);
  modport sink   (input valid, elapsed_seconds, output ready);
endinterface

FILE: rtl/core/dte_calendar.sv
// ---------------------------------------------------------------------------
// dte_calendar
// Three stages: date fields to signed day count since the epoch.
// ---------------------------------------------------------------------------
`include "datetime_to_epoch_seconds_core_macros.svh"

module dte_calendar
  import dte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  output logic        vld_o,
  output dte_days_t   days_o
);

  logic [2:0] vld_q;

  // stage 1
  logic [11:0] p_d;
  logic [9:0]  q4y_d, q4p_d;
  logic [19:0] prod_y, prod_p;
  logic [5:0]  q100y_d, q100p_d;
  logic [9:0]  doy_base_d;
  logic signed [12:0] yd_d;

  logic [9:0]  q4y_q, q4p_q;
  logic [5:0]  q100y_q, q100p_q;
  logic        mod4z_q, after_q, late_q;
  logic [9:0]  doy_base_q;
  logic signed [12:0] yd_q;
  logic [4:0]  h1_q;
  logic [5:0]  m1_q, s1_q;

  // stage 2
  logic        leap;
  logic [10:0] lb_full;
  logic [9:0]  lb_d, doy_d;
  logic signed [DaysW-1:0] yd_ext, yd365_d;

  logic [9:0]  lb_q, doy_q;
  logic signed [DaysW-1:0] yd365_q;
  logic [4:0]  h2_q;
  logic [5:0]  m2_q, s2_q;

  // stage 3
  dte_days_t days_d, days_q;

  always_comb begin
    p_d        = year_i - 12'd1;
    q4y_d      = year_i[11:2];
    q4p_d      = p_d[11:2];
    prod_y     = q4y_d * Recip25;
    prod_p     = q4p_d * Recip25;
    q100y_d    = prod_y[Recip25Shift+5:Recip25Shift];
    q100p_d    = prod_p[Recip25Shift+5:Recip25Shift];
    doy_base_d = {1'b0, DoyOffset[month_i]} + {5'd0, day_i};
    yd_d       = $signed({1'b0, year_i}) - $signed({1'b0, EpochYear});
  end

  always_comb begin
    // leap: divisible by 4 and (year/4 not a multiple of 25, or year/100 a multiple of 4)
    leap    = mod4z_q && (({4'd0, q100y_q} * 10'd25 != q4y_q) || (q100y_q[1:0] == 2'd0));
    lb_full = {1'b0, q4p_q} - {5'd0, q100p_q} + {7'd0, q100p_q[5:2]} - LeapsBeforeEpoch;
    lb_d    = after_q ? lb_full[9:0] : 10'd0;
    doy_d   = doy_base_q + {9'd0, late_q & leap};
    yd_ext  = DaysW'(yd_q);
    yd365_d = yd_ext * 22'sd365;
  end

  always_comb begin
    days_d.days   = $signed({{(DaysW-10){1'b0}}, doy_q}) + yd365_q
                  + $signed({{(DaysW-10){1'b0}}, lb_q}) - 22'sd1;
    days_d.hour   = h2_q;
    days_d.minute = m2_q;
    days_d.second = s2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q4y_q      <= q4y_d;
      q4p_q      <= q4p_d;
      q100y_q    <= q100y_d;
      q100p_q    <= q100p_d;
      mod4z_q    <= (year_i[1:0] == 2'd0);
      after_q    <= (year_i > EpochYear);
      late_q     <= (month_i >= MonthMarch);
      doy_base_q <= doy_base_d;
      yd_q       <= yd_d;
      h1_q       <= hour_i;
      m1_q       <= minute_i;
      s1_q       <= second_i;

      lb_q       <= lb_d;
      doy_q      <= doy_d;
      yd365_q    <= yd365_d;
      h2_q       <= h1_q;
      m2_q       <= m1_q;
      s2_q       <= s1_q;

      days_q     <= days_d;
    end
  end

  assign vld_o  = vld_q[2];
  assign days_o = days_q;

  `DTE_ASSERT(a_cal_hold, !en_i |=> $stable(vld_q), "calendar stages moved during stall")
  `DTE_ASSERT(a_cal_adv, en_i |=> (vld_q[2:1] == $past(vld_q[1:0])),
              "calendar valid bits did not advance")

endmodule

FILE: rtl/core/dte_seconds.sv
// ---------------------------------------------------------------------------
// dte_seconds
// Three stages: day count to seconds, one multiply-add per stage, mod 2^32.
// ---------------------------------------------------------------------------
`include "datetime_to_epoch_seconds_core_macros.svh"

module dte_seconds
  import dte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  dte_days_t   days_i,
  output logic        vld_o,
  output logic [31:0] secs_o
);

  logic [2:0]  vld_q;
  logic [31:0] hours_d, mins_d, secs_d;
  logic [31:0] hours_q, mins_q, secs_q;
  logic [5:0]  min_q, sec1_q, sec2_q;

  always_comb begin
    hours_d = 32'(days_i.days) * 32'd24 + {27'd0, days_i.hour};
    mins_d  = hours_q * 32'd60 + {26'd0, min_q};
    secs_d  = mins_q * 32'd60 + {26'd0, sec2_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hours_q <= hours_d;
      min_q   <= days_i.minute;
      sec1_q  <= days_i.second;
      mins_q  <= mins_d;
      sec2_q  <= sec1_q;
      secs_q  <= secs_d;
    end
  end

  assign vld_o  = vld_q[2];
  assign secs_o = secs_q;

  `DTE_ASSERT(a_sec_adv, en_i |=> (vld_q[0] == $past(vld_i)),
              "seconds stage lost or duplicated a beat")

endmodule

FILE: rtl/core/datetime_to_epoch_seconds_core.sv
// ---------------------------------------------------------------------------
// datetime_to_epoch_seconds_core
// Gregorian calendar time to seconds since 2010-01-01 00:00:00, mod 2^32.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  (sink)  : one beat carries year, month, day, hour, minute, second.
//   out_o (source): one beat carries elapsed_seconds for each input beat,
//                   in input order.
//   Pipeline: 3 stages for the day count, 3 stages for the
//   hour/minute/second multiply-adds.
//   Throughput: one beat per cycle; a new beat enters every cycle while
//   the output is taken or the last stage is empty.
//   Stall: when out_o.valid is high and out_o.ready low, every stage holds
//   and in_i.ready drops in the same cycle; bubbles inside the pipe are
//   not squeezed out; all stages share one enable and advance together.
//   Reset: rst_ni clears all stage valid bits asynchronously; the pipe
//   comes out of reset empty and ready. No configuration, no state between
//   beats. Out-of-range fields follow the same wrapping arithmetic.
// ---------------------------------------------------------------------------
`include "datetime_to_epoch_seconds_core_macros.svh"

module datetime_to_epoch_seconds_core
  import dte_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dte_in_if.sink    in_i,
  dte_out_if.source out_o
);

  logic      en;
  logic      cal_vld;
  dte_days_t cal_days;

  // Whole pipe moves when the output slot is free or being taken.
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  dte_calendar u_cal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (in_i.valid),
    .year_i   (in_i.year),
    .month_i  (in_i.month),
    .day_i    (in_i.day),
    .hour_i   (in_i.hour),
    .minute_i (in_i.minute),
    .second_i (in_i.second),
    .vld_o    (cal_vld),
    .days_o   (cal_days)
  );

  dte_seconds u_sec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cal_vld),
    .days_i (cal_days),
    .vld_o  (out_o.valid),
    .secs_o (out_o.elapsed_seconds)
  );

  `DTE_ASSERT_RST(a_rst_empty, !rst_ni |=> !out_o.valid, "output valid after reset")
  `DTE_ASSERT(a_out_rise, $rose(out_o.valid) |-> $past(en), "output appeared without advance")

endmodule

FILE: test/datetime_to_epoch_seconds_core_test.sv
// ---------------------------------------------------------------------------
// datetime_to_epoch_seconds_core_test
// Self-checking bench for the calendar-to-epoch-seconds core. Calendar
// times go in over the input channel. A local model predicts seconds since
// 2010-01-01 00:00:00 mod 2^32. Every output beat is compared in order.
// Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module datetime_to_epoch_seconds_core_test
  import dte_pkg::*;
();

  // Random phase: beat count, and the point where idling stops
  localparam int unsigned RandomBeats = 1500;
  localparam int unsigned QuietFrom   = 1200;
  localparam int unsigned DrainCycles = 16;   // pipe is 6 deep, plus margin

  logic clk_i;
  logic rst_ni;

  dte_in_if  in_if ();
  dte_out_if out_if ();

  datetime_to_epoch_seconds_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted elapsed seconds, oldest first; filled on input beats
  logic [31:0] pending_secs [$];
  int unsigned sent_beats;
  int unsigned checked_beats;
  int unsigned mismatches;
  bit          src_idle_on;
  bit          sink_stall_on;

  // -------------------------------------------------------------------------
  // Clock: 20-unit period
  // -------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case a beat never comes back or the input never gets ready.
  // The slowest correct run is ~1525 beats; this timeout is ~7x its length.
  initial begin
    #10_000_000;
    $display("datetime_to_epoch_seconds_core_test: errors");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Seconds-since-epoch predictor, all arithmetic 32-bit and wrapping
  // -------------------------------------------------------------------------

  // Leap years in [1, last] for last >= 0
  function automatic logic [31:0] leap_count(input logic [31:0] last);
    return last / 32'd4 - last / 32'd100 + last / 32'd400;
  endfunction

  function automatic logic [31:0] predict_elapsed(
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
  );
    logic [31:0] yr;
    logic [31:0] mo;
    logic [31:0] leap_day;
    logic [31:0] leaps;
    logic [31:0] days;
    yr = {20'd0, year};
    mo = {28'd0, month};
    leap_day = (((yr % 32'd4) == 0 && (yr % 32'd100) != 0) || (yr % 32'd400) == 0)
             ? 32'd1 : 32'd0;
    // March onward (month codes 13..15 too): closed-form month term.
    // Month zero takes the February path.
    if (mo >= 32'd3) begin
      days = (32'd13 * (mo + 32'd1)) / 32'd5 - 32'd7 + (mo - 32'd1) * 32'd28
           + {27'd0, day} + leap_day;
    end else if (mo == 32'd1) begin
      days = {27'd0, day};
    end else begin
      days = 32'd31 + {27'd0, day};
    end
    // Leap days of whole years since the epoch; none for years at or below it
    leaps = 32'd0;
    if (yr > {20'd0, EpochYear}) begin
      leaps = leap_count(yr - 32'd1) - leap_count({20'd0, EpochYear} - 32'd1);
    end
    days = days + 32'd365 * (yr - {20'd0, EpochYear}) + leaps - 32'd1;
    return ((days * 32'd24 + {27'd0, hour}) * 32'd60 + {26'd0, minute}) * 32'd60
         + {26'd0, second};
  endfunction

  // -------------------------------------------------------------------------
  // Input side: one beat per call, with an optional idle burst up front.
  // valid drops only for an idle burst, so back-to-back beats keep it high.
  // -------------------------------------------------------------------------
  task automatic send_time(
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
  );
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.year   <= year;
    in_if.month  <= month;
    in_if.day    <= day;
    in_if.hour   <= hour;
    in_if.minute <= minute;
    in_if.second <= second;
    // ready as seen at the edge decides acceptance
    do @(posedge clk_i); while (!in_if.ready);
    pending_secs.push_back(predict_elapsed(year, month, day, hour, minute, second));
    sent_beats++;
  endtask

  // -------------------------------------------------------------------------
  // Output side: ready drops in random bursts while stalls are enabled
  // -------------------------------------------------------------------------
  initial begin
    int unsigned burst;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_stall_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 19);
        out_if.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Result check: each output beat against the oldest prediction
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_secs.size() == 0) begin
        $error("elapsed_seconds: no beat expected, actual %0d", out_if.elapsed_seconds);
        mismatches++;
      end else begin
        want = pending_secs.pop_front();
        if (out_if.elapsed_seconds !== want) begin
          $error("elapsed_seconds: expected %0d, actual %0d", want,
                 out_if.elapsed_seconds);
          mismatches++;
        end
        checked_beats++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Epoch itself, day zero wrapping below it, last second of 2145,
  // and all-zero / all-one fields
  task automatic test_epoch_bounds();
    send_time(12'd2010, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_time(12'd2010, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0);
    send_time(12'd2145, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_time(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_time(12'hfff, 4'hf, 5'h1f, 5'h1f, 6'h3f, 6'h3f);
  endtask

  // Every month code, 0 and 13..15 included, alternating leap/common year
  task automatic test_month_codes();
    for (int m = 0; m < 16; m++) begin
      send_time(m[0] ? 12'd2012 : 12'd2011, m[3:0], 5'(m + 1), 5'(m), 6'(m * 3),
                6'(59 - m));
    end
  endtask

  // Century rule, 400-year rule, and a year before the epoch
  task automatic test_leap_rules();
    send_time(12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_time(12'd2000, 4'd3, 5'd1, 5'd12, 6'd30, 6'd30);
    send_time(12'd2400, 4'd3, 5'd1, 5'd0, 6'd0, 6'd1);
    send_time(12'd2009, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
  endtask

  // Mostly well-formed times, some full-width noise on every field.
  // Idling stops for the tail so back-to-back beats get exercised too.
  task automatic test_random_times();
    for (int unsigned i = 0; i < RandomBeats; i++) begin
      if (i == QuietFrom) begin
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
      end
      if ($urandom_range(0, 99) < 85) begin
        send_time(12'($urandom_range(2010, 2145)), 4'($urandom_range(1, 12)),
                  5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                  6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
      end else begin
        send_time(12'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                  6'($urandom), 6'($urandom));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.year    = '0;
    in_if.month   = '0;
    in_if.day     = '0;
    in_if.hour    = '0;
    in_if.minute  = '0;
    in_if.second  = '0;
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    sent_beats    = 0;
    checked_beats = 0;
    mismatches    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_epoch_bounds();
    test_month_codes();
    test_leap_rules();
    test_random_times();

    in_if.valid <= 1'b0;
    // Drain; the stop timer covers a pipe that never empties
    while (pending_secs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d calendar times, checked %0d conversions.", sent_beats,
             checked_beats);
    $display("Covered: month codes 0-15, leap rules, field extremes, random noise.");
    if (mismatches == 0) begin
      $display("datetime_to_epoch_seconds_core_test: clean");
    end else begin
      $display("datetime_to_epoch_seconds_core_test: errors");
    end
    $finish;
  end

endmodule
